>>> src/fcl_pkg.sv
package fcl_pkg;

    localparam int IN_SIZE  = 16;
    localparam int OUT_SIZE = 16;
    localparam int ACC_N    = (IN_SIZE > OUT_SIZE) ? IN_SIZE : OUT_SIZE;
    localparam int W_DEPTH  = IN_SIZE * OUT_SIZE;
    localparam int W_AW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int KW       = (ACC_N > 1) ? $clog2(ACC_N) : 1;
    localparam int IN_AW    = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
    localparam int OUT_AW   = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
    localparam int NW       = $clog2(ACC_N + 1) + 1;
    localparam int CNT_W    = $clog2(ACC_N + 3) + 1;
    localparam int ACC_W    = 40;

    localparam logic [15:0] LR_RESET = 16'd655;

    localparam logic [1:0] KIND_FWD   = 2'd0;
    localparam logic [1:0] KIND_BWD   = 2'd1;
    localparam logic [1:0] KIND_WLOAD = 2'd2;
    localparam logic [1:0] KIND_BLOAD = 2'd3;

    localparam logic RES_FWD = 1'b0;
    localparam logic RES_BWD = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] value;
        logic [11:0]        index;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [15:0] result_value;
        logic [5:0]         result_index;
        logic               result_last;
    } out_item_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } ring_ctl_t;

endpackage

>>> src/fcl_ram.sv
module fcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/fcl_acc_cell.sv
module fcl_acc_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fcl_pkg::ring_ctl_t                ctl,
    input  logic signed [fcl_pkg::ACC_W-1:0]  d,
    output logic signed [fcl_pkg::ACC_W-1:0]  q
);
    import fcl_pkg::*;

    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctl.clear) begin
            acc_reg <= '0;
        end else if (ctl.shift) begin
            acc_reg <= d;
        end
    end

    assign q = acc_reg;

endmodule

>>> src/fc_layer_forward_backward_sgd_unit.sv
// Fully connected layer (IN_SIZE inputs, OUT_SIZE outputs, signed Q4.12) with an SGD
// update on the backward pass. Each forward or backward element with an index in range
// is processed in the run state, with s_ready low: the weight memory is read one row or
// column entry per cycle, and a ring of ACC_N accumulator cells rotates by one each
// cycle past a single multiply-accumulate unit; backward weight updates are written back
// from stage st3, behind the reads. Weight and bias loads, and elements with an
// out-of-range index, are handled without a run. A transaction marked last then emits
// OUT_SIZE (forward) or IN_SIZE (backward) results, one per cycle while m_ready is high,
// and clears the accumulators. The user must write the learning_rate register (lr_reg)
// through the cfg channel only while the block is idle; the block does not enforce it.
module fc_layer_forward_backward_sgd_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  fcl_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fcl_pkg::out_item_t  m_data
);
    import fcl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
        logic signed [15:0] r;
        if (v > 41'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -41'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [15:0]           lr_reg;
    in_item_t              item_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  st1_v_reg, st2_v_reg, st3_v_reg;
    logic [KW-1:0]         st1_k_reg, st2_k_reg, st3_k_reg;
    logic signed [31:0]    prod_reg, xe_reg;
    logic signed [15:0]    w2_reg, w3_reg;
    logic signed [48:0]    lrp_reg;
    logic signed [32:0]    bstep_reg;
    logic [KW-1:0]         em_reg;
    out_item_t             out_reg;
    logic                  out_v_reg;
    logic signed [15:0]    bias_reg [OUT_SIZE];
    logic signed [15:0]    xin_reg [IN_SIZE];

    logic                  accept, is_fwd, idx_ok, issue, slot_free, emit_go, emit_done;
    logic [KW-1:0]         k_iss;
    logic [NW-1:0]         vec_n;
    logic                  ram_we;
    logic [W_AW-1:0]       ram_waddr, ram_raddr;
    logic [15:0]           ram_wdata, ram_rdata;
    logic signed [15:0]    x_rd, bias_rd, w_new;
    logic [OUT_AW-1:0]     bias_addr;
    logic signed [ACC_W-1:0] acc_q [ACC_N];
    logic signed [ACC_W-1:0] tail_d;
    logic signed [40:0]    acc_sum, emit_t;
    logic signed [49:0]    wstep_full;
    logic signed [33:0]    bstep_full;
    logic signed [17:0]    w_diff;
    logic signed [18:0]    b_diff;
    ring_ctl_t             ring_ctl;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign is_fwd    = (item_reg.kind == KIND_FWD);
    assign vec_n     = is_fwd ? NW'(OUT_SIZE) : NW'(IN_SIZE);
    assign k_iss     = cnt_reg[KW-1:0];
    assign issue     = (state_reg == ST_RUN) && (cnt_reg < CNT_W'(ACC_N));
    assign slot_free = !out_v_reg || m_ready;
    assign emit_go   = (state_reg == ST_EMIT) && slot_free;
    assign emit_done = emit_go && (NW'(em_reg) == vec_n - NW'(1));

    always_comb begin
        idx_ok = 1'b0;
        if (s_data.kind == KIND_FWD) begin
            idx_ok = (s_data.index < 12'(IN_SIZE));
        end else if (s_data.kind == KIND_BWD) begin
            idx_ok = (s_data.index < 12'(OUT_SIZE));
        end
    end

    // weight memory addressing
    always_comb begin
        ram_raddr = '0;
        if (NW'(k_iss) < vec_n) begin
            if (is_fwd) begin
                ram_raddr = W_AW'(item_reg.index[IN_AW-1:0]) * W_AW'(OUT_SIZE) + W_AW'(k_iss);
            end else begin
                ram_raddr = W_AW'(k_iss) * W_AW'(OUT_SIZE) + W_AW'(item_reg.index[OUT_AW-1:0]);
            end
        end
    end

    assign wstep_full = (50'(lrp_reg) + (50'sd1 <<< 39)) >>> 40;
    assign w_diff     = 18'(w3_reg) - 18'(wstep_full);
    assign w_new      = sat16(41'(w_diff));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (accept && s_data.kind == KIND_WLOAD && s_data.index < 12'(W_DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = s_data.index[W_AW-1:0];
            ram_wdata = s_data.value;
        end else if (st3_v_reg && !is_fwd && NW'(st3_k_reg) < NW'(IN_SIZE)) begin
            ram_we    = 1'b1;
            ram_waddr = W_AW'(st3_k_reg) * W_AW'(OUT_SIZE) + W_AW'(item_reg.index[OUT_AW-1:0]);
            ram_wdata = w_new;
        end
    end

    fcl_ram #(
        .WIDTH (16),
        .DEPTH (W_DEPTH)
    ) u_weights (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // accumulator ring
    assign acc_sum = 41'(acc_q[0]) + 41'(prod_reg);
    always_comb begin
        tail_d = acc_q[0];
        if (st2_v_reg && NW'(st2_k_reg) < vec_n) begin
            if (acc_sum > 41'sh7f_ffff_ffff) begin
                tail_d = 40'sh7f_ffff_ffff;
            end else if (acc_sum < -41'sh80_0000_0000) begin
                tail_d = -40'sh80_0000_0000;
            end else begin
                tail_d = acc_sum[ACC_W-1:0];
            end
        end
    end

    assign ring_ctl.shift = st2_v_reg || emit_go;
    assign ring_ctl.clear = emit_done;

    for (genvar g = 0; g < ACC_N; g++) begin : g_cell
        logic signed [ACC_W-1:0] cell_d;
        if (g == ACC_N - 1) begin : g_tail
            assign cell_d = tail_d;
        end else begin : g_link
            assign cell_d = acc_q[g+1];
        end
        fcl_acc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ring_ctl),
            .d       (cell_d),
            .q       (acc_q[g])
        );
    end

    assign x_rd      = (NW'(st1_k_reg) < NW'(IN_SIZE)) ? xin_reg[st1_k_reg[IN_AW-1:0]]
                                                       : 16'sd0;
    assign bias_addr = (state_reg == ST_EMIT) ? em_reg[OUT_AW-1:0]
                                              : item_reg.index[OUT_AW-1:0];
    assign bias_rd   = bias_reg[bias_addr];
    assign bstep_full = (34'(bstep_reg) + 34'sd32768) >>> 16;
    assign b_diff     = 19'(bias_rd) - 19'(bstep_full);
    assign emit_t     = 41'(acc_q[0]) + (is_fwd ? (41'(bias_rd) <<< 12) : 41'sd0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_data.kind == KIND_FWD || s_data.kind == KIND_BWD)) begin
                    if (idx_ok) begin
                        state_next = ST_RUN;
                    end else if (s_data.last) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_RUN: begin
                if (cnt_reg == CNT_W'(ACC_N + 2)) begin
                    state_next = item_reg.last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lr_reg    <= LR_RESET;
            cnt_reg   <= '0;
            st1_v_reg <= 1'b0;
            st2_v_reg <= 1'b0;
            st3_v_reg <= 1'b0;
            em_reg    <= '0;
            out_v_reg <= 1'b0;
            for (int b = 0; b < OUT_SIZE; b++) begin
                bias_reg[b] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                lr_reg <= cfg_data;
            end
            cnt_reg   <= (state_reg == ST_RUN) ? cnt_reg + CNT_W'(1) : '0;
            st1_v_reg <= issue;
            st2_v_reg <= st1_v_reg;
            st3_v_reg <= st2_v_reg;
            if (accept && s_data.kind == KIND_BLOAD && s_data.index < 12'(OUT_SIZE)) begin
                bias_reg[s_data.index[OUT_AW-1:0]] <= s_data.value;
            end else if (state_reg == ST_RUN && cnt_reg == '0 && !is_fwd) begin
                bias_reg[bias_addr] <= sat16(41'(b_diff));
            end
            if (emit_go) begin
                out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
            if (emit_done) begin
                em_reg <= '0;
            end else if (emit_go) begin
                em_reg <= em_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg  <= s_data;
            bstep_reg <= 33'(signed'({1'b0, lr_reg})) * 33'(s_data.value);
            if (s_data.kind == KIND_FWD && idx_ok) begin
                xin_reg[s_data.index[IN_AW-1:0]] <= s_data.value;
            end
        end
        st1_k_reg <= k_iss;
        st2_k_reg <= st1_k_reg;
        st3_k_reg <= st2_k_reg;
        prod_reg  <= 32'(item_reg.value) * 32'(signed'(ram_rdata));
        xe_reg    <= 32'(x_rd) * 32'(item_reg.value);
        w2_reg    <= ram_rdata;
        w3_reg    <= w2_reg;
        lrp_reg   <= 49'(signed'({1'b0, lr_reg})) * 49'(xe_reg);
        if (emit_go) begin
            out_reg.result_kind  <= is_fwd ? RES_FWD : RES_BWD;
            out_reg.result_value <= sat16((emit_t + 41'sd2048) >>> 12);
            out_reg.result_index <= 6'(em_reg);
            out_reg.result_last  <= (NW'(em_reg) == vec_n - NW'(1));
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_mac_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        st2_v_reg |-> (state_reg == ST_RUN))
        else $error("accumulate outside of run");
    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_done |=> (acc_q[0] == '0))
        else $error("accumulators not cleared after emission");
    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_EMIT))
        else $error("result appeared outside emission");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && cnt_reg != '0) |-> $past(state_reg == ST_RUN))
        else $error("run counter out of step");
`endif

endmodule
